@@ sv/nrb_pkg.sv @@
// Shared types, constants and the control store of the NDEF record builder.
package nrb_pkg;

  localparam int OFF_W  = 11;
  localparam int CNT_W  = 9;
  localparam int NEED_W = 13;

  localparam logic [OFF_W-1:0] LIMIT_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] CNT_MAX     = 9'd511;
  localparam logic [10:0]      SHORT_MAX   = 11'd255;

  localparam logic [7:0] FLAG_MB = 8'h80;
  localparam logic [7:0] FLAG_ME = 8'h40;
  localparam logic [7:0] FLAG_SR = 8'h10;
  localparam logic [7:0] FLAG_IL = 8'h08;

  typedef enum logic [2:0] {
    MODE_BEGIN = 3'd0,
    MODE_START = 3'd1,
    MODE_DATA  = 3'd2,
    MODE_END   = 3'd3,
    MODE_READ  = 3'd4,
    MODE_RESET = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_STATE  = 2'd1,
    ST_BUFFER = 2'd2,
    ST_UNEXP  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'd0,
    S_BEGIN  = 5'd1,
    S_RESET  = 5'd2,
    S_END    = 5'd3,
    S_DATA   = 5'd4,
    S_NOP    = 5'd5,
    S_READ   = 5'd6,
    S_RDRESP = 5'd7,
    S_START  = 5'd8,
    S_CLRME  = 5'd9,
    S_FLAGS  = 5'd10,
    S_TLEN   = 5'd11,
    S_PB3    = 5'd12,
    S_PB2    = 5'd13,
    S_PB1    = 5'd14,
    S_PB0    = 5'd15,
    S_ILEN   = 5'd16,
    S_COMMIT = 5'd17,
    S_FAIL   = 5'd18
  } step_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_BEGIN, OP_RESET, OP_END, OP_DATA,
    OP_RDREQ, OP_RDRESP, OP_CHECK, OP_COMMIT, OP_FAIL
  } op_t;

  typedef enum logic [3:0] {
    W_NONE, W_CLRME, W_FLAGS, W_TLEN, W_PB3, W_PB2, W_PB1, W_PB0, W_ILEN, W_DATA
  } wsel_t;

  typedef enum logic [1:0] {
    J_NONE, J_FAIL, J_SR, J_NOIL
  } jcond_t;

  typedef struct packed {
    op_t    op;
    wsel_t  wsel;
    logic   emit;
    logic   ret;
    jcond_t jcond;
    step_t  target;
  } ctrl_t;

  typedef struct packed {
    ctrl_t cw;
    logic  go;
    logic  accept;
  } seq_t;

  typedef struct packed {
    logic fail;
    logic sr;
    logic il;
    logic out_free;
  } cond_t;

  function automatic ctrl_t cw(op_t op, wsel_t ws, logic emit, logic ret,
                               jcond_t jc, step_t tgt);
    ctrl_t c;
    c.op     = op;
    c.wsel   = ws;
    c.emit   = emit;
    c.ret    = ret;
    c.jcond  = jc;
    c.target = tgt;
    return c;
  endfunction

  // Control store: one word per step.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    unique case (s)
      S_IDLE:   c = cw(OP_NONE,   W_NONE,  1'b0, 1'b1, J_NONE, S_IDLE);
      S_BEGIN:  c = cw(OP_BEGIN,  W_NONE,  1'b1, 1'b1, J_NONE, S_IDLE);
      S_RESET:  c = cw(OP_RESET,  W_NONE,  1'b1, 1'b1, J_NONE, S_IDLE);
      S_END:    c = cw(OP_END,    W_NONE,  1'b1, 1'b1, J_NONE, S_IDLE);
      S_DATA:   c = cw(OP_DATA,   W_DATA,  1'b1, 1'b1, J_NONE, S_IDLE);
      S_NOP:    c = cw(OP_NONE,   W_NONE,  1'b1, 1'b1, J_NONE, S_IDLE);
      S_READ:   c = cw(OP_RDREQ,  W_NONE,  1'b0, 1'b0, J_NONE, S_IDLE);
      S_RDRESP: c = cw(OP_RDRESP, W_NONE,  1'b1, 1'b1, J_NONE, S_IDLE);
      S_START:  c = cw(OP_CHECK,  W_NONE,  1'b0, 1'b0, J_FAIL, S_FAIL);
      S_CLRME:  c = cw(OP_NONE,   W_CLRME, 1'b0, 1'b0, J_NONE, S_IDLE);
      S_FLAGS:  c = cw(OP_NONE,   W_FLAGS, 1'b0, 1'b0, J_NONE, S_IDLE);
      S_TLEN:   c = cw(OP_NONE,   W_TLEN,  1'b0, 1'b0, J_SR,   S_PB0);
      S_PB3:    c = cw(OP_NONE,   W_PB3,   1'b0, 1'b0, J_NONE, S_IDLE);
      S_PB2:    c = cw(OP_NONE,   W_PB2,   1'b0, 1'b0, J_NONE, S_IDLE);
      S_PB1:    c = cw(OP_NONE,   W_PB1,   1'b0, 1'b0, J_NONE, S_IDLE);
      S_PB0:    c = cw(OP_NONE,   W_PB0,   1'b0, 1'b0, J_NOIL, S_COMMIT);
      S_ILEN:   c = cw(OP_NONE,   W_ILEN,  1'b0, 1'b0, J_NONE, S_IDLE);
      S_COMMIT: c = cw(OP_COMMIT, W_NONE,  1'b1, 1'b1, J_NONE, S_IDLE);
      S_FAIL:   c = cw(OP_FAIL,   W_NONE,  1'b1, 1'b1, J_NONE, S_IDLE);
      default:  c = cw(OP_NONE,   W_NONE,  1'b0, 1'b1, J_NONE, S_IDLE);
    endcase
    return c;
  endfunction

  // First step of the program for each mode.
  function automatic step_t entry(logic [2:0] mode);
    step_t s;
    unique case (mode)
      MODE_BEGIN: s = S_BEGIN;
      MODE_START: s = S_START;
      MODE_DATA:  s = S_DATA;
      MODE_END:   s = S_END;
      MODE_READ:  s = S_READ;
      MODE_RESET: s = S_RESET;
      default:    s = S_NOP;
    endcase
    return s;
  endfunction

endpackage

@@ sv/nrb_sequencer.sv @@
// Step counter and control store lookup of the NDEF record builder.
module nrb_sequencer
  import nrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] in_mode,
  input  cond_t      cond,
  output seq_t       seq
);

  step_t pc;
  step_t pc_next;
  ctrl_t cw_cur;
  logic  go;
  logic  accept;
  logic  jump;

  always_comb begin
    cw_cur = ucode(pc);
    // A step that delivers a result waits until the output register is free.
    go     = !cw_cur.emit || cond.out_free;
    accept = cw_cur.ret && go && in_valid;
    unique case (cw_cur.jcond)
      J_FAIL:  jump = cond.fail;
      J_SR:    jump = cond.sr;
      J_NOIL:  jump = !cond.il;
      default: jump = 1'b0;
    endcase
    priority if (accept) begin
      pc_next = entry(in_mode);
    end else if (!go) begin
      pc_next = pc;
    end else if (cw_cur.ret) begin
      pc_next = S_IDLE;
    end else if (jump) begin
      pc_next = cw_cur.target;
    end else begin
      pc_next = step_t'(pc + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign seq.cw     = cw_cur;
  assign seq.go     = go;
  assign seq.accept = accept;

endmodule

@@ sv/nrb_datapath.sv @@
// Item latch, message registers, byte store and result register of the NDEF record builder.
module nrb_datapath
  import nrb_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  seq_t             seq,
  input  logic             cfg_wr_en,
  input  logic [10:0]      cfg_wr_data,
  input  logic [2:0]       tnf,
  input  logic [7:0]       type_length,
  input  logic [7:0]       id_length,
  input  logic [10:0]      payload_length,
  input  logic [7:0]       data_byte,
  input  logic [9:0]       read_address,
  input  logic             out_stall,
  output cond_t            cond,
  output logic             out_valid,
  output logic [1:0]       status,
  output logic [10:0]      message_length,
  output logic [7:0]       read_data,
  output logic [8:0]       records_written
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int XW = 17;
  localparam int DEPTH_CAP = (STORE_DEPTH > 2047) ? 2047 : STORE_DEPTH;

  // Latched item.
  logic [2:0]  tnf_q;
  logic [7:0]  tlen_q;
  logic [7:0]  ilen_q;
  logic [10:0] plen_q;
  logic [7:0]  dbyte_q;
  logic [9:0]  raddr_q;

  // Message state.
  logic [OFF_W-1:0] limit;
  logic [OFF_W-1:0] woff;
  logic [OFF_W-1:0] woff_next;
  logic [OFF_W-1:0] lrs;
  logic [OFF_W-1:0] lrs_next;
  logic [CNT_W-1:0] rtot;
  logic [CNT_W-1:0] rtot_next;
  logic [OFF_W-1:0] bexp;
  logic [OFF_W-1:0] bexp_next;
  logic             mopen;
  logic             mopen_next;
  logic [7:0]       last_flags;
  status_t          st;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata;

  logic [OFF_W-1:0]  eff_limit;
  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] need_end;
  logic              sr;
  logic              il;
  status_t           chk;
  logic [7:0]        flags;
  logic              data_ok;
  logic              clr_ok;
  logic              rd_ok;
  logic              wr_en;
  logic [OFF_W-1:0]  wr_off;
  logic [7:0]        wr_data;
  logic              advance;
  status_t           res_status;
  logic              out_free;

  always_comb begin
    sr = plen_q <= SHORT_MAX;
    il = ilen_q != 8'd0;
    eff_limit = (limit < OFF_W'(DEPTH_CAP)) ? limit : OFF_W'(DEPTH_CAP);
    need = NEED_W'(2) + (sr ? NEED_W'(1) : NEED_W'(4)) + NEED_W'(il)
         + NEED_W'(tlen_q) + NEED_W'(ilen_q) + NEED_W'(plen_q);
    need_end = NEED_W'(woff) + need;
    priority if (!mopen || bexp != '0) begin
      chk = ST_STATE;
    end else if (need_end > NEED_W'(eff_limit)) begin
      chk = ST_BUFFER;
    end else begin
      chk = ST_OK;
    end
    flags = ((rtot == '0) ? FLAG_MB : 8'h00) | FLAG_ME | (sr ? FLAG_SR : 8'h00)
          | (il ? FLAG_IL : 8'h00) | {5'b0, tnf_q};
    data_ok = mopen && bexp != '0;
    clr_ok  = rtot != '0 && lrs < woff;
    rd_ok   = XW'(raddr_q) < XW'(woff) && XW'(raddr_q) < XW'(STORE_DEPTH);
    out_free = !out_valid || !out_stall;
  end

  // Store write port.
  always_comb begin
    wr_off  = woff;
    wr_data = 8'h00;
    advance = 1'b1;
    wr_en   = seq.go;
    unique case (seq.cw.wsel)
      W_CLRME: begin
        wr_off  = lrs;
        wr_data = last_flags & ~FLAG_ME;
        advance = 1'b0;
        wr_en   = seq.go && clr_ok;
      end
      W_FLAGS: wr_data = flags;
      W_TLEN:  wr_data = tlen_q;
      W_PB3:   wr_data = 8'h00;
      W_PB2:   wr_data = 8'h00;
      W_PB1:   wr_data = {5'b0, plen_q[10:8]};
      W_PB0:   wr_data = plen_q[7:0];
      W_ILEN:  wr_data = ilen_q;
      W_DATA: begin
        wr_data = dbyte_q;
        wr_en   = seq.go && data_ok;
      end
      default: begin
        advance = 1'b0;
        wr_en   = 1'b0;
      end
    endcase
  end

  // Message register updates.
  always_comb begin
    woff_next  = woff;
    lrs_next   = lrs;
    rtot_next  = rtot;
    bexp_next  = bexp;
    mopen_next = mopen;
    if (seq.go) begin
      if (wr_en && advance) begin
        woff_next = woff + OFF_W'(1);
      end
      if (seq.cw.wsel == W_FLAGS) begin
        lrs_next = woff;
      end
      unique case (seq.cw.op)
        OP_BEGIN, OP_RESET: begin
          woff_next  = '0;
          lrs_next   = '0;
          rtot_next  = '0;
          bexp_next  = '0;
          mopen_next = seq.cw.op == OP_BEGIN;
        end
        OP_END: begin
          if (mopen && bexp == '0) begin
            mopen_next = 1'b0;
          end
        end
        OP_DATA: begin
          if (data_ok) begin
            bexp_next = bexp - OFF_W'(1);
          end
        end
        OP_COMMIT: begin
          bexp_next = OFF_W'(tlen_q) + OFF_W'(ilen_q) + plen_q;
          if (rtot != CNT_MAX) begin
            rtot_next = rtot + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (seq.cw.op)
      OP_END:    res_status = (mopen && bexp == '0) ? ST_OK : ST_STATE;
      OP_DATA:   res_status = !mopen ? ST_STATE : (bexp == '0 ? ST_UNEXP : ST_OK);
      OP_RDRESP: res_status = rd_ok ? ST_OK : ST_BUFFER;
      OP_FAIL:   res_status = st;
      default:   res_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (seq.accept) begin
      tnf_q   <= tnf;
      tlen_q  <= type_length;
      ilen_q  <= id_length;
      plen_q  <= payload_length;
      dbyte_q <= data_byte;
      raddr_q <= read_address;
    end
    if (seq.cw.op == OP_CHECK) begin
      st <= chk;
    end
    if (seq.cw.wsel == W_FLAGS) begin
      last_flags <= flags;
    end
    if (seq.go && seq.cw.emit) begin
      status          <= res_status;
      message_length  <= woff_next;
      records_written <= rtot_next;
      read_data       <= (seq.cw.op == OP_RDRESP && rd_ok) ? rdata : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_RESET;
      woff      <= '0;
      lrs       <= '0;
      rtot      <= '0;
      bexp      <= '0;
      mopen     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
      woff  <= woff_next;
      lrs   <= lrs_next;
      rtot  <= rtot_next;
      bexp  <= bexp_next;
      mopen <= mopen_next;
      if (seq.go && seq.cw.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(XW'(wr_off))] <= wr_data;
    end
    if (seq.cw.op == OP_RDREQ) begin
      rdata <= mem[AW'(XW'(raddr_q))];
    end
  end

  assign cond.fail     = chk != ST_OK;
  assign cond.sr       = sr;
  assign cond.il       = il;
  assign cond.out_free = out_free;

endmodule

@@ sv/ndef_message_record_builder.sv @@
// Top level of the NDEF message record builder.
// This block assembles an NDEF message in an internal byte store of STORE_DEPTH bytes and
// answers every accepted input beat with exactly one result beat. A small program held in a
// read-only control store steps a plain datapath: each mode enters the program at its own
// step, and the final step of each item delivers the result into an output register and, in
// that same cycle, can take the next input beat. Begin, end, reset and data-byte beats are
// therefore handled by their entry step alone, so data bytes stream into the store at one
// per cycle while the output is not stalled. A read beat has a request and a response step,
// because the store's read port is registered. A start-record beat runs a fit check, a step
// to clear the ME flag of the previous record, a write step per header byte on the single
// store write port (flags, type length, one- or four-byte payload length, id length if any)
// and a commit; a record that does not fit, or comes in the wrong state, goes from the fit
// check straight to a fail step. The buffer limit register (reset value 1024) caps the usable
// store below STORE_DEPTH and may only be written while the block is idle. The store itself
// is not cleared after reset; only bytes already written in the current message are read.
module ndef_message_record_builder
  import nrb_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [2:0]  tnf,
  input  logic [7:0]  type_length,
  input  logic [7:0]  id_length,
  input  logic [10:0] payload_length,
  input  logic [7:0]  data_byte,
  input  logic [9:0]  read_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [10:0] message_length,
  output logic [7:0]  read_data,
  output logic [8:0]  records_written
);

  seq_t  seq;
  cond_t cond;

  // The sequencer sequences steps; the datapath owns every register the steps act on.
  nrb_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (mode),
    .cond     (cond),
    .seq      (seq)
  );

  nrb_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .seq             (seq),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .tnf             (tnf),
    .type_length     (type_length),
    .id_length       (id_length),
    .payload_length  (payload_length),
    .data_byte       (data_byte),
    .read_address    (read_address),
    .out_stall       (out_stall),
    .cond            (cond),
    .out_valid       (out_valid),
    .status          (status),
    .message_length  (message_length),
    .read_data       (read_data),
    .records_written (records_written)
  );

  // Input beats are taken only while idle or on a step that ends an item and is not held by the output.
  assign in_stall = !(seq.cw.ret && seq.go);

endmodule
